// ----- design/scmv_pkg.sv -----
// Shared constants, types and helpers for the sparse column matrix unit.
`default_nettype none
package scmv_pkg;

  localparam int MAX_DIM        = 32;
  localparam int MAX_PER_COLUMN = 8;
  localparam int SLOTS          = MAX_DIM * MAX_PER_COLUMN;
  localparam int DIM_CAP        = (MAX_DIM < 32) ? MAX_DIM : 32;

  localparam int DIM_W  = $clog2(MAX_DIM);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int FILL_W = $clog2(MAX_PER_COLUMN + 1);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int DCNT_W = $clog2(DIM_CAP + 1);
  localparam int ACC_W  = 64 + SLOT_W;

  // Fixed field widths
  localparam int OP_W   = 3;
  localparam int IDX_W  = 5;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 6;
  localparam int ENT_W  = IDX_W + VAL_W;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 3'd0,
    OP_SET   = 3'd1,
    OP_GET   = 3'd2,
    OP_LOAD  = 3'd3,
    OP_AX    = 3'd4,
    OP_XA    = 3'd5
  } op_t;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_SAT   = 2'd3;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic             clear;
    logic             mul;
    logic             acc;
    logic [DIM_W-1:0] idx;
  } mac_ctl_t;

  // Slot address of entry k in column col
  function automatic logic [SLOT_W-1:0] slot_addr(input logic [DIM_W-1:0] col,
                                                  input logic [FILL_W-1:0] k);
    slot_addr = SLOT_W'(SLOT_W'(col) * SLOT_W'(MAX_PER_COLUMN) + SLOT_W'(k));
  endfunction

  // Clamp a dimension register into 1..DIM_CAP
  function automatic logic [DCNT_W-1:0] clamp_dim(input logic [CFG_W-1:0] r);
    if (r == '0) clamp_dim = DCNT_W'(1);
    else if (32'(r) > DIM_CAP) clamp_dim = DCNT_W'(DIM_CAP);
    else clamp_dim = DCNT_W'(r);
  endfunction

endpackage
`default_nettype wire

// ----- design/scmv_if.sv -----
// Handshake channel interfaces for input items and result items.
`default_nettype none
interface scmv_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [4:0]  row_number;
  logic [4:0]  column_number;
  logic signed [31:0] data_value;

  modport source (output valid, operation, row_number, column_number, data_value,
                  input ready);
  modport sink (input valid, operation, row_number, column_number, data_value,
                output ready);
endinterface

interface scmv_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic [4:0]  result_position;
  logic        last_of_run;
  logic        entry_found;
  logic [1:0]  status_code;
  logic [8:0]  nonzero_count;

  modport source (output valid, result_value, result_position, last_of_run, entry_found,
                  status_code, nonzero_count, input ready);
  modport sink (input valid, result_value, result_position, last_of_run, entry_found,
                status_code, nonzero_count, output ready);
endinterface
`default_nettype wire

// ----- design/scmv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module scmv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- design/scmv_mac.sv -----
// Shared multiplier with per-index exact accumulators and round/saturate readout.
`default_nettype none
module scmv_mac (
  input  wire logic                         clk,
  input  wire scmv_pkg::mac_ctl_t           ctl,
  input  wire logic signed [31:0]           mul_a,
  input  wire logic signed [31:0]           mul_b,
  input  wire logic [scmv_pkg::DIM_W-1:0]   rd_idx,
  output logic signed [31:0]                res_value,
  output logic                              res_sat
);
  import scmv_pkg::*;

  logic signed [63:0]      prod_r;
  logic [DIM_W-1:0]        idx_r;
  logic signed [ACC_W-1:0] acc_r [MAX_DIM];
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-17:0] shf;
  logic                    fits;

  // Multiply stage, then accumulate into the selected sum
  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= mul_a * mul_b;
      idx_r  <= ctl.idx;
    end
    if (ctl.clear) begin
      for (int i = 0; i < MAX_DIM; i++) begin
        acc_r[i] <= '0;
      end
    end else if (ctl.acc) begin
      acc_r[idx_r] <= acc_r[idx_r] + ACC_W'(prod_r);
    end
  end

  // Round half up to Q16.16 and saturate
  always_comb begin
    rnd  = acc_r[rd_idx] + ACC_W'(32'sh8000);
    shf  = rnd[ACC_W-1:16];
    fits = (shf[ACC_W-17:31] == '0) || (shf[ACC_W-17:31] == '1);
    res_sat = !fits;
    if (fits) res_value = shf[31:0];
    else if (rnd[ACC_W-1]) res_value = 32'sh8000_0000;
    else res_value = 32'sh7FFF_FFFF;
  end
endmodule
`default_nettype wire

// ----- design/sparse_column_matrix_spmv_unit.sv -----
// Top level: sparse column matrix store with matrix-vector products.
//
// Entries live in a 256 x 37 RAM, up to 8 per column sorted by row; one
// sequencer drives the RAM port and one shared 32x32 multiplier. The block
// takes one transaction at a time. Clear, load and undefined codes answer
// straight from idle. Get and set scan the column for the row; a set that
// inserts or removes then shifts the later entries of the column. A*x and
// x^T*A walk every stored entry of the active columns, then send one result
// per row or column at up to one per cycle while the receiver accepts them.
`default_nettype none
module sparse_column_matrix_spmv_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  scmv_in_if.sink          in_ch,
  scmv_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import scmv_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOC_RD, S_LOC_CHK, S_DECIDE, S_SHIFT, S_SH_RD, S_SH_WR,
    S_WALK, S_W_MUL, S_W_ACC, S_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [CFG_W-1:0]      rows_reg_r, cols_reg_r;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [IDX_W-1:0]      row_r, row_nxt, col_r, col_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt, hv_r, hv_nxt;
  logic [FILL_W-1:0]     k_r, k_nxt, pos_r, pos_nxt;
  logic                  hit_r, hit_nxt;
  logic [DCNT_W-1:0]     c_r, c_nxt, e_r, e_nxt;
  logic [FILL_W-1:0]     fill_r [MAX_DIM];
  logic [FILL_W-1:0]     fill_nxt [MAX_DIM];
  logic signed [VAL_W-1:0] vec_r [MAX_DIM];
  logic signed [VAL_W-1:0] vec_nxt [MAX_DIM];
  logic [CNT_W-1:0]      nz_r, nz_nxt;

  logic                  ov_r, ov_nxt;
  logic signed [VAL_W-1:0] ovalue_r, ovalue_nxt;
  logic [IDX_W-1:0]      opos_r, opos_nxt;
  logic                  olast_r, olast_nxt, ofound_r, ofound_nxt;
  logic [STAT_W-1:0]     ostat_r, ostat_nxt;
  logic                  respond;

  logic [DCNT_W-1:0]     rows, cols, run_len;
  logic [DIM_W-1:0]      cidx, wcol;
  logic [FILL_W-1:0]     cfill, wfill;
  logic [FILL_W:0]       k_inc;
  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr, ram_raddr;
  logic [ENT_W-1:0]      ram_wdata, ram_rdata;
  logic [IDX_W-1:0]      rd_row;
  logic signed [VAL_W-1:0] rd_val;
  mac_ctl_t              mctl;
  logic signed [VAL_W-1:0] mul_a, mul_b;
  logic signed [VAL_W-1:0] res_value;
  logic                  res_sat;
  logic                  cfg_wr;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_COLS) ? 32'(cols_reg_r) : 32'(rows_reg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_reg_r <= CFG_W'(32);
      cols_reg_r <= CFG_W'(32);
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_ROWS) rows_reg_r <= cfg_pwdata[CFG_W-1:0];
      else cols_reg_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  assign rows    = clamp_dim(rows_reg_r);
  assign cols    = clamp_dim(cols_reg_r);
  assign run_len = (op_r == OP_AX) ? rows : cols;
  assign cidx    = DIM_W'(col_r);
  assign cfill   = fill_r[cidx];
  assign wcol    = c_r[DIM_W-1:0];
  assign wfill   = fill_r[wcol];
  assign k_inc   = {1'b0, k_r} + (FILL_W+1)'(1);
  assign rd_row  = ram_rdata[ENT_W-1:VAL_W];
  assign rd_val  = ram_rdata[VAL_W-1:0];

  scmv_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  scmv_mac u_mac (
    .clk       (clk),
    .ctl       (mctl),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .rd_idx    (e_r[DIM_W-1:0]),
    .res_value (res_value),
    .res_sat   (res_sat)
  );

  assign in_ch.ready            = (state_r == S_IDLE) && !ov_r;
  assign out_ch.valid           = ov_r;
  assign out_ch.result_value    = ovalue_r;
  assign out_ch.result_position = opos_r;
  assign out_ch.last_of_run     = olast_r;
  assign out_ch.entry_found     = ofound_r;
  assign out_ch.status_code     = ostat_r;
  assign out_ch.nonzero_count   = nz_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r; row_nxt = row_r; col_nxt = col_r; val_nxt = val_r; hv_nxt = hv_r;
    k_nxt = k_r; pos_nxt = pos_r; hit_nxt = hit_r; c_nxt = c_r; e_nxt = e_r;
    fill_nxt = fill_r; vec_nxt = vec_r; nz_nxt = nz_r;
    ov_nxt = ov_r && !out_ch.ready;
    ovalue_nxt = ovalue_r; opos_nxt = opos_r; olast_nxt = olast_r;
    ofound_nxt = ofound_r; ostat_nxt = ostat_r;
    respond = 1'b0;
    ram_we = 1'b0;
    ram_waddr = slot_addr(cidx, k_r);
    ram_wdata = ram_rdata;
    ram_raddr = slot_addr(cidx, k_r);
    mctl = '0;
    mul_a = rd_val;
    mul_b = vec_r[wcol];

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          op_nxt  = in_ch.operation;
          row_nxt = in_ch.row_number;
          col_nxt = in_ch.column_number;
          val_nxt = in_ch.data_value;
          k_nxt   = '0;
          c_nxt   = '0;
          e_nxt   = '0;
          hit_nxt = 1'b0;
          case (in_ch.operation)
            OP_CLEAR: begin
              for (int i = 0; i < MAX_DIM; i++) begin
                fill_nxt[i] = '0;
              end
              nz_nxt = '0;
              respond = 1'b1;
              ostat_nxt = ST_OK;
            end
            OP_SET, OP_GET: begin
              if (DCNT_W'(in_ch.row_number) >= rows ||
                  DCNT_W'(in_ch.column_number) >= cols) begin
                respond = 1'b1;
                ostat_nxt = ST_RANGE;
              end else begin
                state_nxt = S_LOC_RD;
              end
            end
            OP_LOAD: begin
              respond = 1'b1;
              if (32'(in_ch.column_number) >= MAX_DIM) begin
                ostat_nxt = ST_RANGE;
              end else begin
                vec_nxt[DIM_W'(in_ch.column_number)] = in_ch.data_value;
                ostat_nxt = ST_OK;
              end
            end
            OP_AX, OP_XA: begin
              mctl.clear = 1'b1;
              state_nxt = S_WALK;
            end
            default: begin
              respond = 1'b1;
              ostat_nxt = ST_RANGE;
              olast_nxt = 1'b0;
            end
          endcase
        end
      end

      // Scan the column for the row
      S_LOC_RD: begin
        if (k_r >= cfill) begin
          pos_nxt = cfill;
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_LOC_CHK;
        end
      end

      S_LOC_CHK: begin
        hv_nxt = rd_val;
        if (row_r == rd_row) begin
          hit_nxt = 1'b1;
          pos_nxt = k_r;
          state_nxt = S_DECIDE;
        end else if (row_r < rd_row) begin
          pos_nxt = k_r;
          state_nxt = S_DECIDE;
        end else begin
          k_nxt = k_inc[FILL_W-1:0];
          state_nxt = S_LOC_RD;
        end
      end

      S_DECIDE: begin
        if (op_r == OP_GET) begin
          respond = 1'b1;
          ostat_nxt = ST_OK;
          ofound_nxt = hit_r;
          if (hit_r) ovalue_nxt = hv_r;
        end else if (hit_r) begin
          if (val_r != '0) begin
            ram_we = 1'b1;
            ram_waddr = slot_addr(cidx, pos_r);
            ram_wdata = {row_r, val_r};
            respond = 1'b1;
            ostat_nxt = ST_OK;
            ofound_nxt = 1'b1;
          end else begin
            k_nxt = pos_r;
            state_nxt = S_SHIFT;
          end
        end else if (val_r == '0) begin
          respond = 1'b1;
          ostat_nxt = ST_OK;
        end else if (32'(cfill) >= MAX_PER_COLUMN) begin
          respond = 1'b1;
          ostat_nxt = ST_FULL;
        end else begin
          k_nxt = cfill;
          state_nxt = S_SHIFT;
        end
      end

      // Close the gap (remove) or open one (insert)
      S_SHIFT: begin
        if (val_r == '0) begin
          if (k_inc < {1'b0, cfill}) begin
            state_nxt = S_SH_RD;
          end else begin
            fill_nxt[cidx] = cfill - FILL_W'(1);
            nz_nxt = nz_r - CNT_W'(1);
            respond = 1'b1;
            ostat_nxt = ST_OK;
            ofound_nxt = 1'b1;
          end
        end else if (k_r > pos_r) begin
          state_nxt = S_SH_RD;
        end else begin
          ram_we = 1'b1;
          ram_waddr = slot_addr(cidx, pos_r);
          ram_wdata = {row_r, val_r};
          fill_nxt[cidx] = cfill + FILL_W'(1);
          nz_nxt = nz_r + CNT_W'(1);
          respond = 1'b1;
          ostat_nxt = ST_OK;
        end
      end

      S_SH_RD: begin
        ram_raddr = (val_r == '0) ? slot_addr(cidx, k_inc[FILL_W-1:0])
                                  : slot_addr(cidx, k_r - FILL_W'(1));
        state_nxt = S_SH_WR;
      end

      S_SH_WR: begin
        ram_we = 1'b1;
        k_nxt = (val_r == '0) ? k_inc[FILL_W-1:0] : k_r - FILL_W'(1);
        state_nxt = S_SHIFT;
      end

      // Walk stored entries column by column
      S_WALK: begin
        ram_raddr = slot_addr(wcol, k_r);
        if (c_r >= cols) begin
          state_nxt = S_EMIT;
        end else if (k_r >= wfill) begin
          c_nxt = c_r + DCNT_W'(1);
          k_nxt = '0;
        end else begin
          state_nxt = S_W_MUL;
        end
      end

      S_W_MUL: begin
        mctl.mul = 1'b1;
        if (op_r == OP_AX) begin
          mctl.idx = DIM_W'(rd_row);
        end else begin
          mctl.idx = wcol;
          mul_b = vec_r[DIM_W'(rd_row)];
          if (DCNT_W'(rd_row) >= rows) mul_a = '0;
        end
        k_nxt = k_inc[FILL_W-1:0];
        state_nxt = S_W_ACC;
      end

      S_W_ACC: begin
        mctl.acc = 1'b1;
        state_nxt = S_WALK;
      end

      // Send one result per row or column
      S_EMIT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          ovalue_nxt = res_value;
          opos_nxt = IDX_W'(e_r);
          olast_nxt = (e_r + DCNT_W'(1)) == run_len;
          ofound_nxt = 1'b0;
          ostat_nxt = res_sat ? ST_SAT : ST_OK;
          e_nxt = e_r + DCNT_W'(1);
          if ((e_r + DCNT_W'(1)) == run_len) state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Single-result answer; fields not set above hold their defaults
    if (respond) begin
      ov_nxt = 1'b1;
      state_nxt = S_IDLE;
      opos_nxt = '0;
      if (!(state_r == S_IDLE && op_nxt != OP_CLEAR && op_nxt != OP_SET &&
            op_nxt != OP_GET && op_nxt != OP_LOAD)) begin
        olast_nxt = 1'b1;
      end
      if (!(state_r == S_DECIDE && op_r == OP_GET && hit_r)) ovalue_nxt = '0;
      if (!((state_r == S_DECIDE && (op_r == OP_GET || hit_r)) ||
            (state_r == S_SHIFT && val_r == '0))) begin
        ofound_nxt = 1'b0;
      end
    end
  end

  // State, stores and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      nz_r    <= '0;
      for (int i = 0; i < MAX_DIM; i++) begin
        fill_r[i] <= '0;
        vec_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      nz_r    <= nz_nxt;
      fill_r  <= fill_nxt;
      vec_r   <= vec_nxt;
    end
    op_r <= op_nxt; row_r <= row_nxt; col_r <= col_nxt; val_r <= val_nxt;
    hv_r <= hv_nxt; k_r <= k_nxt; pos_r <= pos_nxt; hit_r <= hit_nxt;
    c_r <= c_nxt; e_r <= e_nxt;
    ovalue_r <= ovalue_nxt; opos_r <= opos_nxt; olast_r <= olast_nxt;
    ofound_r <= ofound_nxt; ostat_r <= ostat_nxt;
  end
endmodule
`default_nettype wire

// ----- design/scmv_checker.sv -----
// Port-level checks for the sparse column matrix unit, bound to the top level.
`default_nettype none
module scmv_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_value,
  input wire logic        out_found,
  input wire logic [1:0]  out_status,
  input wire logic [8:0]  out_count
);
  import scmv_pkg::*;

  // A pending result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result changed while stalled");

  // No new transaction while a result waits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

  // A hit always reports ok
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK)
    else $error("hit with error status");

  // Saturated results sit at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SAT |->
      out_value == 32'h7FFF_FFFF || out_value == 32'h8000_0000)
    else $error("saturated value off rail");

  // Entry count stays within capacity
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_count) <= SLOTS)
    else $error("entry count over capacity");
endmodule

bind sparse_column_matrix_spmv_unit scmv_checker u_scmv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_value  (out_ch.result_value),
  .out_found  (out_ch.entry_found),
  .out_status (out_ch.status_code),
  .out_count  (out_ch.nonzero_count)
);
`default_nettype wire
